// ----- src/abs_pkg.sv -----
// Package for the alternating bit sender: sizes, field widths, codes
// and the controller state type. Used by the top level.
// Depends on nothing.
`default_nettype none

package abs_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int PAYLOAD_BYTES = 20;

    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int BIDX_W      = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int STORE_DEPTH = QUEUE_DEPTH * PAYLOAD_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int CSUM_W    = 13;
    localparam int TICK_W    = 16;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 24;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd20;

    localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [KIND_W-1:0] KIND_HDR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_RD,
        S_HDR,
        S_BYTE,
        S_DROP
    } state_t;

endpackage

`default_nettype wire

// ----- src/abs_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read port. No dependencies.
`default_nettype none

module abs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/alternating_bit_sender_top.sv -----
// Top level of the alternating bit sender: queue control, ack check,
// retransmit timer and output register. Uses abs_pkg and two abs_ram.
//
// Channel   Dir  Contents (lowest bit first)
// cfg       in   cfg_we, cfg_wdata = timeout_ticks
// s_axis    in   tuser = op; tdata = data_byte, ack_seqnum, ack_acknum, ack_checksum
// m_axis    out  tuser = kind; tdata = seq_out, checksum_out, payload_byte, 2 zero bits;
//                tlast = last
//
// An input transaction is taken when the controller is idle.
// A transaction that sends a packet keeps the block busy for one payload and
// checksum memory read, then one header and twenty payload transactions.
// A stall on m_axis holds the controller, later payload reads are issued only
// when the output register frees up. After reset the queue is empty and the
// memories need no clearing.
`default_nettype none

module alternating_bit_sender_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [abs_pkg::TICK_W-1:0]      cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // data_byte[7:0], ack_seqnum[39:8], ack_acknum[71:40], ack_checksum[103:72]
    input  wire logic [abs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  wire logic [abs_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // seq_out[0], checksum_out[13:1], payload_byte[21:14], zero[23:22]
    output logic      [abs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // kind[1:0]
    output logic      [abs_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int SW = abs_pkg::SLOT_W;
    localparam int CW = abs_pkg::COUNT_W;
    localparam int BW = abs_pkg::BIDX_W;
    localparam int AW = abs_pkg::STORE_AW;
    localparam int KW = abs_pkg::CSUM_W;
    localparam int TW = abs_pkg::TICK_W;

    abs_pkg::state_t state_reg, state_next;

    logic [TW-1:0] timeout_reg;
    logic [SW-1:0] write_slot_reg, write_slot_next;
    logic [SW-1:0] read_slot_reg, read_slot_next;
    logic [CW-1:0] queued_count_reg, queued_count_next;
    logic [BW-1:0] byte_index_reg, byte_index_next;
    logic [KW-1:0] running_sum_reg, running_sum_next;
    logic          sender_seq_reg, sender_seq_next;
    logic          awaiting_ack_reg, awaiting_ack_next;
    logic [TW-1:0] ticks_left_reg, ticks_left_next;
    logic          dropping_reg, dropping_next;
    logic [BW-1:0] byte_cnt_reg, byte_cnt_next;

    logic                            m_valid_reg, m_valid_next;
    logic [abs_pkg::KIND_W-1:0]      m_kind_reg, m_kind_next;
    logic                            m_seq_reg, m_seq_next;
    logic [KW-1:0]                   m_csum_reg, m_csum_next;
    logic [abs_pkg::BYTE_W-1:0]      m_byte_reg, m_byte_next;
    logic                            m_last_reg, m_last_next;

    logic [abs_pkg::OP_W-1:0]        op;
    logic [abs_pkg::BYTE_W-1:0]      data_byte;
    logic [abs_pkg::WORD_W-1:0]      ack_seqnum, ack_acknum, ack_checksum;
    logic                            accept;
    logic                            drop_now;
    logic                            last_in_byte;
    logic                            ack_ok;
    logic [KW-1:0]                   sum_new;
    logic                            out_free;
    logic                            out_load;
    logic                            last_out_byte;

    logic                            pay_we, pay_re;
    logic [AW-1:0]                   pay_waddr, pay_raddr;
    logic [abs_pkg::BYTE_W-1:0]      pay_rdata;
    logic                            chk_we, chk_re;
    logic [KW-1:0]                   chk_rdata;
    logic [AW-1:0]                   head_base;

    logic [CW:0]                     slot_sum;
    logic [CW:0]                     slot_wrap;

    assign op           = s_axis_tuser;
    assign data_byte    = s_axis_tdata[7:0];
    assign ack_seqnum   = s_axis_tdata[39:8];
    assign ack_acknum   = s_axis_tdata[71:40];
    assign ack_checksum = s_axis_tdata[103:72];

    assign accept       = s_axis_tvalid && s_axis_tready;
    assign drop_now     = (byte_index_reg == '0)
                          ? (queued_count_reg >= CW'(abs_pkg::QUEUE_DEPTH))
                          : dropping_reg;
    assign last_in_byte = (byte_index_reg == BW'(abs_pkg::PAYLOAD_BYTES - 1));
    assign sum_new      = running_sum_reg
                          + {{(KW - abs_pkg::BYTE_W){data_byte[7]}}, data_byte};
    assign ack_ok       = ((ack_seqnum + ack_acknum) == ack_checksum)
                          && (ack_acknum[31:1] == '0)
                          && (ack_acknum[0] == sender_seq_reg)
                          && awaiting_ack_reg;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign last_out_byte = (byte_cnt_reg == BW'(abs_pkg::PAYLOAD_BYTES - 1));
    assign head_base     = AW'(read_slot_reg) * AW'(abs_pkg::PAYLOAD_BYTES);
    assign pay_waddr     = AW'(write_slot_reg) * AW'(abs_pkg::PAYLOAD_BYTES)
                           + AW'(byte_index_reg);

    // Control outputs of the controller.
    always_comb
    begin
        s_axis_tready = (state_reg == abs_pkg::S_IDLE);
        pay_we        = 1'b0;
        chk_we        = 1'b0;
        chk_re        = 1'b0;
        pay_re        = 1'b0;
        pay_raddr     = head_base;
        out_load      = 1'b0;
        case (state_reg)
            abs_pkg::S_IDLE:
            begin
                if (accept && op == abs_pkg::OP_BYTE)
                begin
                    pay_we = !drop_now;
                    chk_we = !drop_now && last_in_byte;
                end
            end
            abs_pkg::S_HDR_RD:
            begin
                chk_re = 1'b1;
                pay_re = 1'b1;
            end
            abs_pkg::S_HDR:
            begin
                out_load = out_free;
            end
            abs_pkg::S_BYTE:
            begin
                out_load  = out_free;
                pay_re    = out_free && !last_out_byte;
                pay_raddr = head_base + AW'(byte_cnt_reg) + AW'(1);
            end
            abs_pkg::S_DROP:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Next state and datapath registers.
    always_comb
    begin
        state_next        = state_reg;
        write_slot_next   = write_slot_reg;
        read_slot_next    = read_slot_reg;
        queued_count_next = queued_count_reg;
        byte_index_next   = byte_index_reg;
        running_sum_next  = running_sum_reg;
        sender_seq_next   = sender_seq_reg;
        awaiting_ack_next = awaiting_ack_reg;
        ticks_left_next   = ticks_left_reg;
        dropping_next     = dropping_reg;
        byte_cnt_next     = byte_cnt_reg;
        m_valid_next      = m_valid_reg && !m_axis_tready;
        m_kind_next       = m_kind_reg;
        m_seq_next        = m_seq_reg;
        m_csum_next       = m_csum_reg;
        m_byte_next       = m_byte_reg;
        m_last_next       = m_last_reg;
        case (state_reg)
            abs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        abs_pkg::OP_BYTE:
                        begin
                            if (last_in_byte)
                            begin
                                byte_index_next  = '0;
                                running_sum_next = '0;
                                dropping_next    = 1'b0;
                                if (drop_now)
                                begin
                                    state_next = abs_pkg::S_DROP;
                                end
                                else
                                begin
                                    write_slot_next =
                                        (write_slot_reg == SW'(abs_pkg::QUEUE_DEPTH - 1))
                                        ? '0 : write_slot_reg + SW'(1);
                                    queued_count_next = queued_count_reg + CW'(1);
                                    if (!awaiting_ack_reg)
                                    begin
                                        awaiting_ack_next = 1'b1;
                                        ticks_left_next   = timeout_reg;
                                        state_next        = abs_pkg::S_HDR_RD;
                                    end
                                end
                            end
                            else
                            begin
                                byte_index_next  = byte_index_reg + BW'(1);
                                running_sum_next = sum_new;
                                dropping_next    = drop_now;
                            end
                        end
                        abs_pkg::OP_ACK:
                        begin
                            if (ack_ok)
                            begin
                                sender_seq_next = !sender_seq_reg;
                                read_slot_next =
                                    (read_slot_reg == SW'(abs_pkg::QUEUE_DEPTH - 1))
                                    ? '0 : read_slot_reg + SW'(1);
                                queued_count_next = (queued_count_reg != '0)
                                                    ? queued_count_reg - CW'(1) : '0;
                                awaiting_ack_next = 1'b0;
                                ticks_left_next   = '0;
                                if (queued_count_reg > CW'(1))
                                begin
                                    awaiting_ack_next = 1'b1;
                                    ticks_left_next   = timeout_reg;
                                    state_next        = abs_pkg::S_HDR_RD;
                                end
                            end
                        end
                        abs_pkg::OP_TICK:
                        begin
                            if (awaiting_ack_reg)
                            begin
                                if (ticks_left_reg <= TW'(1))
                                begin
                                    ticks_left_next = timeout_reg;
                                    state_next      = abs_pkg::S_HDR_RD;
                                end
                                else
                                begin
                                    ticks_left_next = ticks_left_reg - TW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            state_next = abs_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            abs_pkg::S_HDR_RD:
            begin
                state_next = abs_pkg::S_HDR;
            end
            abs_pkg::S_HDR:
            begin
                if (out_load)
                begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = abs_pkg::KIND_HDR;
                    m_seq_next    = sender_seq_reg;
                    m_csum_next   = chk_rdata + {{(KW - 2){1'b0}}, sender_seq_reg, 1'b0};
                    m_byte_next   = '0;
                    m_last_next   = 1'b0;
                    byte_cnt_next = '0;
                    state_next    = abs_pkg::S_BYTE;
                end
            end
            abs_pkg::S_BYTE:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = abs_pkg::KIND_BYTE;
                    m_seq_next   = 1'b0;
                    m_csum_next  = '0;
                    m_byte_next  = pay_rdata;
                    m_last_next  = last_out_byte;
                    if (last_out_byte)
                    begin
                        state_next = abs_pkg::S_IDLE;
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + BW'(1);
                    end
                end
            end
            abs_pkg::S_DROP:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = abs_pkg::KIND_DROP;
                    m_seq_next   = 1'b0;
                    m_csum_next  = '0;
                    m_byte_next  = '0;
                    m_last_next  = 1'b1;
                    state_next   = abs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = abs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= abs_pkg::S_IDLE;
            timeout_reg      <= abs_pkg::TIMEOUT_RESET;
            write_slot_reg   <= '0;
            read_slot_reg    <= '0;
            queued_count_reg <= '0;
            byte_index_reg   <= '0;
            running_sum_reg  <= '0;
            sender_seq_reg   <= 1'b0;
            awaiting_ack_reg <= 1'b0;
            ticks_left_reg   <= '0;
            dropping_reg     <= 1'b0;
            byte_cnt_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            write_slot_reg   <= write_slot_next;
            read_slot_reg    <= read_slot_next;
            queued_count_reg <= queued_count_next;
            byte_index_reg   <= byte_index_next;
            running_sum_reg  <= running_sum_next;
            sender_seq_reg   <= sender_seq_next;
            awaiting_ack_reg <= awaiting_ack_next;
            ticks_left_reg   <= ticks_left_next;
            dropping_reg     <= dropping_next;
            byte_cnt_reg     <= byte_cnt_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_kind_reg <= m_kind_next;
        m_seq_reg  <= m_seq_next;
        m_csum_reg <= m_csum_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    abs_ram #(
        .DEPTH(abs_pkg::STORE_DEPTH),
        .WIDTH(abs_pkg::BYTE_W)
    ) u_payload_ram (
        .clk  (clk),
        .we   (pay_we),
        .waddr(pay_waddr),
        .wdata(data_byte),
        .re   (pay_re),
        .raddr(pay_raddr),
        .rdata(pay_rdata)
    );

    abs_ram #(
        .DEPTH(abs_pkg::QUEUE_DEPTH),
        .WIDTH(abs_pkg::CSUM_W)
    ) u_checksum_ram (
        .clk  (clk),
        .we   (chk_we),
        .waddr(write_slot_reg),
        .wdata(sum_new),
        .re   (chk_re),
        .raddr(read_slot_reg),
        .rdata(chk_rdata)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {2'b00, m_byte_reg, m_csum_reg, m_seq_reg};

    assign slot_sum  = (CW + 1)'(read_slot_reg) + (CW + 1)'(queued_count_reg);
    assign slot_wrap = (slot_sum >= (CW + 1)'(abs_pkg::QUEUE_DEPTH))
                       ? slot_sum - (CW + 1)'(abs_pkg::QUEUE_DEPTH) : slot_sum;

    // A packet is outstanding exactly when the queue holds a message.
    a_awaiting_matches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_ack_reg == (queued_count_reg != '0))
        else $error("Outstanding flag disagrees with queue fill.");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queued_count_reg <= CW'(abs_pkg::QUEUE_DEPTH))
        else $error("Queue fill exceeds its depth.");

    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        slot_wrap == (CW + 1)'(write_slot_reg))
        else $error("Read slot plus fill does not reach the write slot.");

    // The last payload transaction of a packet closes the run and frees the input.
    a_packet_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == abs_pkg::S_BYTE && out_load && last_out_byte)
        |=> (m_axis_tvalid && m_axis_tlast && s_axis_tready))
        else $error("Packet did not end with a last payload transaction.");

    a_header_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != abs_pkg::KIND_HDR)
        |-> (m_axis_tdata[13:0] == '0))
        else $error("Sequence or checksum set outside a header transaction.");

endmodule

`default_nettype wire
